FILE: sv/rrp_pkg.sv
// Package for the RESP request parser: phase codes, event codes, status codes, limits.
// No dependencies.
`default_nettype none
package rrp_pkg;
    localparam int unsigned ARG_COUNT_CAP = 63;
    localparam int unsigned CNT_W = 6;
    localparam int unsigned LEN_W = 21;
    localparam logic [LEN_W:0] NUM_SAT = 22'd2097152;
    localparam logic [CNT_W-1:0] RST_MAX_COUNT = 6'd50;
    localparam logic [LEN_W-1:0] RST_MAX_LEN = 21'd1048576;

    localparam logic [0:0] REG_MAX_COUNT = 1'b0;
    localparam logic [0:0] REG_MAX_LEN = 1'b1;

    localparam logic [2:0] PH_STAR = 3'd0;
    localparam logic [2:0] PH_HEADER = 3'd1;
    localparam logic [2:0] PH_WAITNAME = 3'd2;
    localparam logic [2:0] PH_NAMELEN = 3'd3;
    localparam logic [2:0] PH_NAME = 3'd4;
    localparam logic [2:0] PH_ARGLEN = 3'd5;
    localparam logic [2:0] PH_ARGDATA = 3'd6;
    localparam logic [2:0] PH_DONE = 3'd7;

    localparam logic [2:0] EV_NONE = 3'd0;
    localparam logic [2:0] EV_NAME_BYTE = 3'd1;
    localparam logic [2:0] EV_NAME_END = 3'd2;
    localparam logic [2:0] EV_ARG_BYTE = 3'd3;
    localparam logic [2:0] EV_ARG_END = 3'd4;
    localparam logic [2:0] EV_ERROR = 3'd5;

    localparam logic [1:0] ST_NONE = 2'd0;
    localparam logic [1:0] ST_COMPLETE = 2'd1;
    localparam logic [1:0] ST_INCOMPLETE = 2'd2;
    localparam logic [1:0] ST_ERROR = 2'd3;

    localparam logic [7:0] CH_STAR = 8'h2A;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;

    // classified byte, front to back
    typedef struct packed {
        logic [7:0] data;
        logic       eob;
        logic       digit;
        logic       is_cr;
        logic       is_lf;
        logic       is_star;
        logic       is_dollar;
    } t_tok;

    typedef struct packed {
        logic [2:0]       ev;
        logic [7:0]       data;
        logic [CNT_W-1:0] idx;
        logic [LEN_W-1:0] len;
        logic [CNT_W-1:0] cnt;
        logic [1:0]       status;
    } t_res;
endpackage
`default_nettype wire

FILE: sv/resp_request_parser_unit.sv
// Top level of the RESP array command parser: front classifier, token queue, back parser.
// Depends on rrp_pkg, rrp_front, rrp_queue, rrp_back.
//  channel | signals                                  | dir
//  request | i_valid/o_ready, i_in_byte, i_end_of_buffer | in
//  result  | o_valid/i_ready, o_event_res .. o_final_status | out
//  config  | i_cfg_we, i_cfg_idx, i_cfg_data          | in
// One request per cycle sustained while i_ready stays high; three register stages
// (front reg, queue, result reg), which each request passes through in that order.
// Back parser state machine takes one token a cycle unless the result side stalls; the queue absorbs back stalls.
// Synchronous active-low reset; limits return to 50 and 1048576.
`default_nettype none
module resp_request_parser_unit (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_cfg_we,
    input  wire    [1:0]                i_cfg_idx,
    input  wire    [rrp_pkg::LEN_W-1:0] i_cfg_data,
    input  wire                         i_valid,
    output logic                        o_ready,
    input  wire    [7:0]                i_in_byte,
    input  wire                         i_end_of_buffer,
    output logic                        o_valid,
    input  wire                         i_ready,
    output logic   [2:0]                o_event_res,
    output logic   [7:0]                o_data_byte,
    output logic   [rrp_pkg::CNT_W-1:0] o_arg_index,
    output logic   [rrp_pkg::LEN_W-1:0] o_arg_length,
    output logic   [rrp_pkg::CNT_W-1:0] o_arg_count,
    output logic   [1:0]                o_final_status
);
    import rrp_pkg::*;
    t_tok f_tok, q_tok;
    t_res res;
    logic f_valid, f_ready, q_valid, q_ready;

    rrp_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_byte(i_in_byte),
        .i_eob(i_end_of_buffer), .o_valid(f_valid), .i_ready(f_ready), .o_tok(f_tok)
    );
    rrp_queue u_queue (
        .i_clk, .i_rst_n, .i_valid(f_valid), .o_ready(f_ready), .i_tok(f_tok),
        .o_valid(q_valid), .i_ready(q_ready), .o_tok(q_tok)
    );
    rrp_back u_back (
        .i_clk, .i_rst_n, .i_cfg_we(i_cfg_we && i_cfg_idx[1] == 1'b0),
        .i_cfg_idx(i_cfg_idx[0]), .i_cfg_data,
        .i_valid(q_valid), .o_ready(q_ready), .i_tok(q_tok),
        .o_valid, .i_ready, .o_res(res)
    );

    assign o_event_res = res.ev;
    assign o_data_byte = res.data;
    assign o_arg_index = res.idx;
    assign o_arg_length = res.len;
    assign o_arg_count = res.cnt;
    assign o_final_status = res.status;
endmodule
`default_nettype wire

FILE: sv/rrp_front.sv
// Front stage: accepts request bytes and classifies them into tokens.
// Depends on rrp_pkg.
`default_nettype none
module rrp_front (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_valid,
    output logic          o_ready,
    input  wire    [7:0]  i_byte,
    input  wire           i_eob,
    output logic          o_valid,
    input  wire           i_ready,
    output rrp_pkg::t_tok o_tok
);
    import rrp_pkg::*;
    logic r_valid;
    t_tok r_tok;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_tok = r_tok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_tok.data <= i_byte;
            r_tok.eob <= i_eob;
            r_tok.digit <= (i_byte >= CH_ZERO) && (i_byte <= CH_NINE);
            r_tok.is_cr <= i_byte == CH_CR;
            r_tok.is_lf <= i_byte == CH_LF;
            r_tok.is_star <= i_byte == CH_STAR;
            r_tok.is_dollar <= i_byte == CH_DOLLAR;
        end
    end
endmodule
`default_nettype wire

FILE: sv/rrp_queue.sv
// Two-entry queue of classified tokens between front and back.
// Depends on rrp_pkg.
`default_nettype none
module rrp_queue (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_valid,
    output logic          o_ready,
    input  rrp_pkg::t_tok i_tok,
    output logic          o_valid,
    input  wire           i_ready,
    output rrp_pkg::t_tok o_tok
);
    import rrp_pkg::*;
    t_tok r_mem [2];
    logic r_wp;
    logic r_rp;
    logic [1:0] r_cnt;
    logic wr;
    logic rd;

    assign o_ready = r_cnt != 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_tok = r_mem[r_rp];
    assign wr = i_valid && o_ready;
    assign rd = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (wr) r_wp <= !r_wp;
            if (rd) r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, wr} - {1'b0, rd};
        end
        if (wr) r_mem[r_wp] <= i_tok;
    end
endmodule
`default_nettype wire

FILE: sv/rrp_back.sv
// Back stage: parse state machine, one token per cycle while i_ready is high, registered result.
// Depends on rrp_pkg.
`default_nettype none
module rrp_back (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_cfg_we,
    input  wire                         i_cfg_idx,
    input  wire    [rrp_pkg::LEN_W-1:0] i_cfg_data,
    input  wire                         i_valid,
    output logic                        o_ready,
    input  rrp_pkg::t_tok               i_tok,
    output logic                        o_valid,
    input  wire                         i_ready,
    output rrp_pkg::t_res               o_res
);
    import rrp_pkg::*;
    logic [CNT_W-1:0] r_max_cnt;
    logic [LEN_W-1:0] r_max_len;
    logic [2:0] r_phase, n_phase;
    logic [LEN_W:0] r_acc, n_acc;
    logic r_dig, n_dig;
    logic [CNT_W-1:0] r_total, n_total;
    logic [CNT_W-1:0] r_pos, n_pos;
    logic [LEN_W-1:0] r_ccnt, n_ccnt;
    logic [LEN_W-1:0] r_clen, n_clen;
    logic r_skip, n_skip;
    logic r_err, n_err;
    logic r_valid;
    t_res r_res, n_res;
    logic [LEN_W+4:0] mul;
    logic [LEN_W:0] acc_dig;
    logic [CNT_W:0] pos_inc;
    logic fail;
    logic fire;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res = r_res;
    assign fire = i_valid && o_ready;

    assign mul = ({4'd0, r_acc} << 3) + ({4'd0, r_acc} << 1)
               + {{(LEN_W+1){1'b0}}, i_tok.data[3:0]};
    assign acc_dig = (mul > {4'd0, NUM_SAT}) ? NUM_SAT : mul[LEN_W:0];
    assign pos_inc = {1'b0, r_pos} + 1'b1;

    always_comb begin
        n_phase = r_phase; n_acc = r_acc; n_dig = r_dig; n_total = r_total;
        n_pos = r_pos; n_ccnt = r_ccnt; n_clen = r_clen; n_skip = r_skip;
        n_err = r_err;
        n_res = '0;
        fail = 1'b0;
        if (r_err) begin
        end else if (r_skip) begin
            n_skip = 1'b0;
        end else begin
            case (r_phase)
                PH_STAR: begin
                    if (i_tok.is_star) n_phase = PH_HEADER;
                    else fail = 1'b1;
                end
                PH_HEADER: begin
                    if (i_tok.digit) begin
                        n_acc = acc_dig; n_dig = 1'b1;
                    end else if (i_tok.is_lf) begin
                        if (!r_dig || r_acc == '0
                            || r_acc > {{(LEN_W+1-CNT_W){1'b0}}, r_max_cnt}) begin
                            fail = 1'b1;
                        end else begin
                            n_total = r_acc[CNT_W-1:0] - 1'b1;
                            n_acc = '0; n_dig = 1'b0;
                            n_phase = PH_WAITNAME;
                        end
                    end else if (!i_tok.is_cr) begin
                        fail = 1'b1;
                    end
                end
                PH_WAITNAME: if (i_tok.is_dollar) n_phase = PH_NAMELEN;
                PH_NAMELEN: if (i_tok.is_lf) n_phase = PH_NAME;
                PH_NAME: begin
                    if (i_tok.is_lf) begin
                        n_res.ev = EV_NAME_END;
                        n_pos = '0;
                        n_phase = (r_total == '0) ? PH_DONE : PH_ARGLEN;
                    end else if (!i_tok.is_cr) begin
                        n_res.ev = EV_NAME_BYTE;
                        n_res.data = i_tok.data;
                    end
                end
                PH_ARGLEN: begin
                    if (i_tok.digit) begin
                        n_acc = acc_dig; n_dig = 1'b1;
                    end else if (i_tok.is_lf) begin
                        if (!r_dig || r_acc > {1'b0, r_max_len}) begin
                            fail = 1'b1;
                        end else begin
                            n_clen = r_acc[LEN_W-1:0];
                            n_ccnt = '0;
                            n_acc = '0; n_dig = 1'b0;
                            n_phase = PH_ARGDATA;
                        end
                    end else if (!i_tok.is_cr && !i_tok.is_dollar) begin
                        fail = 1'b1;
                    end
                end
                PH_ARGDATA: begin
                    n_res.idx = r_pos;
                    n_res.len = r_clen;
                    if (r_ccnt >= r_clen) begin
                        n_res.ev = EV_ARG_END;
                        n_ccnt = '0;
                        n_skip = 1'b1;
                        n_pos = pos_inc[CNT_W-1:0];
                        n_phase = (pos_inc >= {1'b0, r_total}) ? PH_DONE : PH_ARGLEN;
                    end else begin
                        n_res.ev = EV_ARG_BYTE;
                        n_res.data = i_tok.data;
                        n_ccnt = r_ccnt + 1'b1;
                    end
                end
                default: fail = 1'b1;
            endcase
        end
        if (fail) begin
            n_err = 1'b1;
            n_res.ev = EV_ERROR;
            n_res.data = '0; n_res.idx = '0; n_res.len = '0;
        end
        n_res.cnt = n_total;
        if (i_tok.eob) begin
            if (n_err) n_res.status = ST_ERROR;
            else if (n_phase == PH_DONE) n_res.status = ST_COMPLETE;
            else n_res.status = ST_INCOMPLETE;
            n_phase = PH_STAR; n_acc = '0; n_dig = 1'b0; n_total = '0;
            n_pos = '0; n_ccnt = '0; n_clen = '0; n_skip = 1'b0; n_err = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_cnt <= RST_MAX_COUNT;
            r_max_len <= RST_MAX_LEN;
            r_phase <= PH_STAR; r_acc <= '0; r_dig <= 1'b0; r_total <= '0;
            r_pos <= '0; r_ccnt <= '0; r_clen <= '0; r_skip <= 1'b0; r_err <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            if (i_cfg_we && i_cfg_idx == REG_MAX_COUNT) r_max_cnt <= i_cfg_data[CNT_W-1:0];
            if (i_cfg_we && i_cfg_idx == REG_MAX_LEN) r_max_len <= i_cfg_data;
            if (o_ready) r_valid <= i_valid;
            if (fire) begin
                r_phase <= n_phase; r_acc <= n_acc; r_dig <= n_dig; r_total <= n_total;
                r_pos <= n_pos; r_ccnt <= n_ccnt; r_clen <= n_clen;
                r_skip <= n_skip; r_err <= n_err;
            end
        end
        if (fire) r_res <= n_res;
    end
endmodule
`default_nettype wire

FILE: sv/rrp_checker.sv
// Port-level checker for resp_request_parser_unit, bound to the top level.
// Depends on rrp_pkg.
`default_nettype none
module rrp_checker (
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       o_valid,
    input wire       i_ready,
    input wire [2:0] o_event_res,
    input wire [7:0] o_data_byte,
    input wire [1:0] o_final_status
);
    import rrp_pkg::*;
    a_ev_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_event_res <= EV_ERROR) else $error("bad event");
    a_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_event_res != EV_NAME_BYTE && o_event_res != EV_ARG_BYTE
        |-> o_data_byte == 8'd0) else $error("stray data");
    a_err_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_event_res == EV_ERROR && o_final_status != ST_NONE
        |-> o_final_status == ST_ERROR) else $error("error status");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_event_res)) else $error("hold");
endmodule

bind resp_request_parser_unit rrp_checker u_rrp_checker (
    .i_clk, .i_rst_n, .o_valid, .i_ready, .o_event_res, .o_data_byte, .o_final_status
);
`default_nettype wire
